// ===== design/teoq_pkg.sv =====
`default_nettype none

package teoq_pkg;

   localparam int QUEUE_DEPTH    = 16;
   localparam int COUNT_BITS     = $clog2(QUEUE_DEPTH + 1);
   localparam int DEVICE_ID_BITS = 8;
   localparam logic [7:0] DEV_MASK = 8'((1 << DEVICE_ID_BITS) - 1);

   // request staging queue between front and back
   localparam int FRONT_DEPTH    = 2;
   localparam int FRONT_PTR_BITS = $clog2(FRONT_DEPTH);
   localparam int FRONT_CNT_BITS = $clog2(FRONT_DEPTH + 1);

   // command codes on the request word
   localparam logic [1:0] CMD_INSERT        = 2'd0;
   localparam logic [1:0] CMD_REMOVE_FIRST  = 2'd1;
   localparam logic [1:0] CMD_REMOVE_DEVICE = 2'd2;

   // internal operation codes after classification
   localparam logic [1:0] OP_IGNORE        = 2'd0;
   localparam logic [1:0] OP_INSERT        = 2'd1;
   localparam logic [1:0] OP_REMOVE_FIRST  = 2'd2;
   localparam logic [1:0] OP_REMOVE_DEVICE = 2'd3;

   // status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_EMPTY    = 2'd2;
   localparam logic [1:0] ST_NOTFOUND = 2'd3;

   typedef struct packed {
      logic [1:0]         command;
      logic [31:0]        event_time;
      logic [7:0]         device_id;
      logic signed [31:0] event_value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic               head_valid;
      logic [31:0]        head_time;
      logic [7:0]         head_device;
      logic signed [31:0] head_value;
      logic [4:0]         entry_count;
   } rsp_type;

   typedef struct packed {
      logic [1:0]         op;
      logic [31:0]        event_time;
      logic [7:0]         device_id;
      logic signed [31:0] event_value;
   } task_type;

   typedef struct packed {
      logic     valid;
      task_type word;
   } task_chan_type;

endpackage

`default_nettype wire

// ===== design/teoq_front.sv =====
`default_nettype none

module teoq_front (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     push,
   output logic                    full,
   input  teoq_pkg::req_type       req_word,
   output teoq_pkg::task_chan_type task_chan,
   input  wire                     task_take
);
   import teoq_pkg::*;

   task_type                  stage_mem [FRONT_DEPTH];
   logic [FRONT_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FRONT_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FRONT_CNT_BITS-1:0] fill_ff, fill_in;
   task_type                  classified;
   logic                      wr_en;
   logic                      rd_en;

   always_comb begin
      classified.event_time  = req_word.event_time;
      classified.device_id   = req_word.device_id & DEV_MASK;
      classified.event_value = req_word.event_value;
      unique case (req_word.command)
         CMD_INSERT:        classified.op = OP_INSERT;
         CMD_REMOVE_FIRST:  classified.op = OP_REMOVE_FIRST;
         CMD_REMOVE_DEVICE: classified.op = OP_REMOVE_DEVICE;
         default:           classified.op = OP_IGNORE;
      endcase
   end

   assign full  = (fill_ff == FRONT_CNT_BITS'(FRONT_DEPTH));
   assign wr_en = push && !full;
   assign rd_en = task_take && task_chan.valid;

   assign task_chan.valid = (fill_ff != '0);
   assign task_chan.word  = stage_mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == FRONT_PTR_BITS'(FRONT_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == FRONT_PTR_BITS'(FRONT_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_en && !rd_en) begin
         fill_in = fill_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stage_mem[wr_ptr_ff] <= classified;
      end
   end

endmodule

`default_nettype wire

// ===== design/teoq_back.sv =====
`default_nettype none

module teoq_back (
   input  wire                     clock,
   input  wire                     reset,
   input  teoq_pkg::task_chan_type task_chan,
   output logic                    task_take,
   output logic                    empty,
   input  wire                     pop,
   output teoq_pkg::rsp_type       rsp_word
);
   import teoq_pkg::*;

   logic [31:0]           slot_time_ff   [QUEUE_DEPTH];
   logic [31:0]           slot_time_in   [QUEUE_DEPTH];
   logic [7:0]            slot_device_ff [QUEUE_DEPTH];
   logic [7:0]            slot_device_in [QUEUE_DEPTH];
   logic signed [31:0]    slot_value_ff  [QUEUE_DEPTH];
   logic signed [31:0]    slot_value_in  [QUEUE_DEPTH];
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  out_valid_ff, out_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic [QUEUE_DEPTH-1:0] later;
   logic [QUEUE_DEPTH-1:0] after;
   logic [QUEUE_DEPTH-1:0] match;
   logic [QUEUE_DEPTH-1:0] shift_up;
   logic                   found;
   logic                   do_insert;
   logic                   do_remove;
   logic [1:0]             status;
   task_type               tsk;

   assign tsk       = task_chan.word;
   assign task_take = task_chan.valid && (!out_valid_ff || pop);
   assign empty     = !out_valid_ff;
   assign rsp_word  = rsp_ff;

   always_comb begin
      found = 1'b0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         later[i] = (COUNT_BITS'(i) < count_ff) && (tsk.event_time < slot_time_ff[i]);
         after[i] = later[i] || (COUNT_BITS'(i) >= count_ff);
         if (tsk.op == OP_REMOVE_FIRST) begin
            match[i] = (i == 0);
         end else begin
            match[i] = (COUNT_BITS'(i) < count_ff) && (slot_device_ff[i] == tsk.device_id);
         end
         found       = found | match[i];
         shift_up[i] = found;
      end
   end

   always_comb begin
      do_insert = 1'b0;
      do_remove = 1'b0;
      status    = ST_OK;
      count_in  = count_ff;
      unique case (tsk.op)
         OP_INSERT: begin
            if (count_ff == COUNT_BITS'(QUEUE_DEPTH)) begin
               status = ST_FULL;
            end else begin
               do_insert = 1'b1;
               count_in  = count_ff + 1'b1;
            end
         end
         OP_REMOVE_FIRST, OP_REMOVE_DEVICE: begin
            if (count_ff == '0) begin
               status = ST_EMPTY;
            end else if (!found) begin
               status = ST_NOTFOUND;
            end else begin
               do_remove = 1'b1;
               count_in  = count_ff - 1'b1;
            end
         end
         default: begin
            status = ST_OK;
         end
      endcase
   end

   always_comb begin
      slot_time_in   = slot_time_ff;
      slot_device_in = slot_device_ff;
      slot_value_in  = slot_value_ff;
      if (do_insert) begin
         if (after[0]) begin
            slot_time_in[0]   = tsk.event_time;
            slot_device_in[0] = tsk.device_id;
            slot_value_in[0]  = tsk.event_value;
         end
         for (int i = 1; i < QUEUE_DEPTH; i++) begin
            if (after[i] && !after[i-1]) begin
               slot_time_in[i]   = tsk.event_time;
               slot_device_in[i] = tsk.device_id;
               slot_value_in[i]  = tsk.event_value;
            end else if (after[i]) begin
               slot_time_in[i]   = slot_time_ff[i-1];
               slot_device_in[i] = slot_device_ff[i-1];
               slot_value_in[i]  = slot_value_ff[i-1];
            end
         end
      end else if (do_remove) begin
         for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            if (shift_up[i]) begin
               slot_time_in[i]   = slot_time_ff[i+1];
               slot_device_in[i] = slot_device_ff[i+1];
               slot_value_in[i]  = slot_value_ff[i+1];
            end
         end
      end
   end

   always_comb begin
      rsp_in             = rsp_ff;
      out_valid_in       = out_valid_ff;
      if (pop && out_valid_ff) begin
         out_valid_in = 1'b0;
      end
      if (task_take) begin
         out_valid_in       = 1'b1;
         rsp_in.status      = status;
         rsp_in.head_valid  = (count_in != '0);
         rsp_in.head_time   = (count_in != '0) ? slot_time_in[0] : '0;
         rsp_in.head_device = (count_in != '0) ? slot_device_in[0] : '0;
         rsp_in.head_value  = (count_in != '0) ? slot_value_in[0] : '0;
         rsp_in.entry_count = 5'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (task_take) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (task_take) begin
         slot_time_ff   <= slot_time_in;
         slot_device_ff <= slot_device_in;
         slot_value_ff  <= slot_value_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/time_ordered_event_queue_top.sv =====
`default_nettype none

// Time-ordered event queue: a sorted store of up to 16 events (time, device, value).
// Request side: drive req_word and raise push; the word is taken on a clock edge
// with push high and full low. Commands: insert, remove first, remove earliest
// event of a device. Every word gives exactly one response word.
// Response side: while empty is low, rsp_word holds the oldest response (status,
// head event after the operation, entry count); raise pop to take it.
// A request passes through the staging queue and then the response register. The sorted
// store does each command with a parallel compare across all slots, so one word
// per cycle is sustained while pop keeps up.
// A two-word staging queue sits between the request decoder and the store, and
// one response register follows the store. When pop is held low the store stops
// after filling the response register, the staging queue fills, and full rises.
// Reset (synchronous, active high) empties the store and both queues; slot
// contents are not cleared and never reach a response before being written.
module time_ordered_event_queue_top (
   input  wire                clock,
   input  wire                reset,
   input  wire                push,
   output logic               full,
   input  teoq_pkg::req_type  req_word,
   output logic               empty,
   input  wire                pop,
   output teoq_pkg::rsp_type  rsp_word
);
   import teoq_pkg::*;

   task_chan_type task_chan;
   logic          task_take;

   teoq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_word  (req_word),
      .task_chan (task_chan),
      .task_take (task_take)
   );

   teoq_back u_back (
      .clock     (clock),
      .reset     (reset),
      .task_chan (task_chan),
      .task_take (task_take),
      .empty     (empty),
      .pop       (pop),
      .rsp_word  (rsp_word)
   );

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_word.entry_count <= 5'(QUEUE_DEPTH)))
      else $error("entry count above queue depth");

   a_head_valid: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_word.head_valid == (rsp_word.entry_count != '0)))
      else $error("head valid disagrees with count");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_word.status == ST_FULL) |-> (rsp_word.entry_count == 5'(QUEUE_DEPTH)))
      else $error("full status with room left");

   a_task_held: assert property (@(posedge clock) disable iff (reset)
      (task_chan.valid && !task_take) |=> task_chan.valid)
      else $error("staged request lost");

endmodule

`default_nettype wire

// ===== bench/time_ordered_event_queue_top_tb.sv =====
`default_nettype none

module time_ordered_event_queue_top_tb;
   import teoq_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int RANDOM_WORDS = 1600;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int IDLE_PCT     = 22;

   typedef struct {
      req_type w;
      bit      fixed;
      rsp_type r;
   } stim_row;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    push = 1'b0;
   logic    pop = 1'b0;
   req_type req_word = '0;
   logic    full;
   logic    empty;
   rsp_type rsp_word;

   logic [31:0] sched_time [QUEUE_DEPTH];
   logic [7:0]  sched_dev [QUEUE_DEPTH];
   logic [31:0] sched_val [QUEUE_DEPTH];
   int          sched_count = 0;

   rsp_type head_reports[$];
   stim_row directed[$];
   int      errors = 0;
   int      words_sent = 0;
   int      cycles = 0;
   int      status_seen [4] = '{0, 0, 0, 0};
   int      peak_count = 0;
   bit      calm = 1'b0;

   time_ordered_event_queue_top dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_word (req_word),
      .empty    (empty),
      .pop      (pop),
      .rsp_word (rsp_word)
   );

   always #5 clock = ~clock;

   function automatic void drop_entry(int pos);
      int i;
      for (i = pos; i + 1 < sched_count; i++) begin
         sched_time[i] = sched_time[i + 1];
         sched_dev[i]  = sched_dev[i + 1];
         sched_val[i]  = sched_val[i + 1];
      end
      sched_count--;
   endfunction

   function automatic rsp_type apply_command(req_type w);
      rsp_type     r;
      int          pos;
      int          hit;
      int          i;
      logic [7:0]  dev;
      r = '0;
      r.status = ST_OK;
      dev = w.device_id & DEV_MASK;
      case (w.command)
         CMD_INSERT: begin
            if (sched_count >= QUEUE_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               pos = 0;
               while (pos < sched_count && !(w.event_time < sched_time[pos])) pos++;
               for (i = sched_count; i > pos; i--) begin
                  sched_time[i] = sched_time[i - 1];
                  sched_dev[i]  = sched_dev[i - 1];
                  sched_val[i]  = sched_val[i - 1];
               end
               sched_time[pos] = w.event_time;
               sched_dev[pos]  = dev;
               sched_val[pos]  = w.event_value;
               sched_count++;
            end
         end
         CMD_REMOVE_FIRST: begin
            if (sched_count == 0) r.status = ST_EMPTY;
            else drop_entry(0);
         end
         CMD_REMOVE_DEVICE: begin
            if (sched_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               hit = -1;
               for (i = 0; i < sched_count; i++) begin
                  if (hit < 0 && sched_dev[i] == dev) hit = i;
               end
               if (hit < 0) r.status = ST_NOTFOUND;
               else drop_entry(hit);
            end
         end
         default: ;
      endcase
      if (sched_count != 0) begin
         r.head_valid  = 1'b1;
         r.head_time   = sched_time[0];
         r.head_device = sched_dev[0];
         r.head_value  = sched_val[0];
      end
      r.entry_count = 5'(sched_count);
      return r;
   endfunction

   function automatic req_type random_word(int insert_pct);
      req_type w;
      w.event_value = $urandom;
      case ($urandom_range(0, 3))
         0, 1: w.event_time = $urandom_range(0, 31);
         2: w.event_time = $urandom;
         default: w.event_time = 32'hFFFF_FFF0 + $urandom_range(0, 15);
      endcase
      if ($urandom_range(0, 99) < 75) w.device_id = $urandom_range(0, 7);
      else w.device_id = $urandom_range(0, 255);
      if ($urandom_range(0, 99) < 4) w.command = CMD_UNUSED;
      else if ($urandom_range(0, 99) < insert_pct) w.command = CMD_INSERT;
      else if ($urandom_range(0, 99) < 40) w.command = CMD_REMOVE_FIRST;
      else w.command = CMD_REMOVE_DEVICE;
      return w;
   endfunction

   task automatic send_word(input req_type w, input bit fixed, input rsp_type r);
      rsp_type predicted;
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (full);
      predicted = apply_command(w);
      head_reports.push_back(fixed ? r : predicted);
      if (sched_count > peak_count) peak_count = sched_count;
      words_sent++;
   endtask

   task automatic flag_field(input string name, input logic [31:0] e, input logic [31:0] a);
      if (e !== a) begin
         $display("%0t mismatch %s: expected %h got %h", $time, name, e, a);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (head_reports.size() == 0) begin
               $display("%0t unexpected word: expected none got %h", $time, rsp_word);
               errors++;
            end else begin
               want = head_reports.pop_front();
               flag_field("status", 32'(want.status), 32'(rsp_word.status));
               flag_field("head_valid", 32'(want.head_valid), 32'(rsp_word.head_valid));
               flag_field("head_time", want.head_time, rsp_word.head_time);
               flag_field("head_device", 32'(want.head_device), 32'(rsp_word.head_device));
               flag_field("head_value", want.head_value, rsp_word.head_value);
               flag_field("entry_count", 32'(want.entry_count), 32'(rsp_word.entry_count));
               status_seen[want.status]++;
            end
         end
         pop <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      int      n;
      int      insert_pct;
      int      pct_choices [5];
      req_type w;
      stim_row row;

      pct_choices = '{10, 25, 50, 75, 95};
      directed.push_back('{req_type'{CMD_REMOVE_FIRST, 32'h0, 8'h0, 32'sh0}, 1'b1,
                           rsp_type'{ST_EMPTY, 1'b0, 32'h0, 8'h0, 32'sh0, 5'd0}});
      directed.push_back('{req_type'{CMD_REMOVE_DEVICE, 32'h0, 8'h0, 32'sh0}, 1'b1,
                           rsp_type'{ST_EMPTY, 1'b0, 32'h0, 8'h0, 32'sh0, 5'd0}});
      directed.push_back('{req_type'{CMD_UNUSED, 32'hFFFF_FFFF, 8'hFF, 32'shFFFF_FFFF}, 1'b1,
                           rsp_type'{ST_OK, 1'b0, 32'h0, 8'h0, 32'sh0, 5'd0}});
      directed.push_back('{req_type'{CMD_INSERT, 32'hFFFF_FFFF, 8'hFF, 32'sh8000_0000}, 1'b1,
                           rsp_type'{ST_OK, 1'b1, 32'hFFFF_FFFF, 8'hFF, 32'sh8000_0000, 5'd1}});
      directed.push_back('{req_type'{CMD_INSERT, 32'h0, 8'h00, 32'sh7FFF_FFFF}, 1'b1,
                           rsp_type'{ST_OK, 1'b1, 32'h0, 8'h00, 32'sh7FFF_FFFF, 5'd2}});
      directed.push_back('{req_type'{CMD_REMOVE_DEVICE, 32'h0, 8'h55, 32'sh0}, 1'b1,
                           rsp_type'{ST_NOTFOUND, 1'b1, 32'h0, 8'h00, 32'sh7FFF_FFFF, 5'd2}});
      // tie on time zero: lands behind the stored one
      directed.push_back('{req_type'{CMD_INSERT, 32'h0, 8'h01, 32'shFFFF_FFFF}, 1'b0, '0});
      directed.push_back('{req_type'{CMD_REMOVE_DEVICE, 32'h0, 8'h01, 32'sh0}, 1'b0, '0});
      for (n = 0; n < QUEUE_DEPTH - 2; n++) begin
         row.w = req_type'{CMD_INSERT, 32'(n / 2), 8'(n * 37 + 3), 32'(n) * 32'h1357_9BDF};
         row.fixed = 1'b0;
         row.r = '0;
         directed.push_back(row);
      end
      directed.push_back('{req_type'{CMD_INSERT, 32'h0, 8'hAA, 32'sh1234_5678}, 1'b1,
                           rsp_type'{ST_FULL, 1'b1, 32'h0, 8'h00, 32'sh7FFF_FFFF, 5'd16}});
      directed.push_back('{req_type'{CMD_REMOVE_DEVICE, 32'h0, 8'hFF, 32'sh0}, 1'b0, '0});
      directed.push_back('{req_type'{CMD_REMOVE_FIRST, 32'h0, 8'h0, 32'sh0}, 1'b0, '0});
      directed.push_back('{req_type'{CMD_UNUSED, 32'h5555_5555, 8'h5A, 32'sh2AAA_AAAA}, 1'b0, '0});

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) send_word(directed[i].w, directed[i].fixed, directed[i].r);

      insert_pct = 50;
      for (n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 80 == 0) insert_pct = pct_choices[$urandom_range(0, 4)];
         calm = (n >= 700 && n < 1000);
         w = random_word(insert_pct);
         send_word(w, 1'b0, '0);
      end
      calm = 1'b0;
      push <= 1'b0;

      while (head_reports.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("sent %0d words, queue depth reached %0d of %0d", words_sent, peak_count,
               QUEUE_DEPTH);
      $display("status seen: ok %0d, full %0d, empty %0d, not found %0d", status_seen[ST_OK],
               status_seen[ST_FULL], status_seen[ST_EMPTY], status_seen[ST_NOTFOUND]);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
design/teoq_pkg.sv
design/teoq_front.sv
design/teoq_back.sv
design/time_ordered_event_queue_top.sv
bench/time_ordered_event_queue_top_tb.sv
